FILE: rtl/bpa_pkg.sv
// Package with the constants, codes and helpers of the buddy page allocator.
package bpa_pkg;

  localparam int PAGE_SHIFT = 12;
  localparam int POOL_SHIFT = 20;
  localparam int LEVELS     = POOL_SHIFT - PAGE_SHIFT;
  localparam int NPAGES     = 1 << LEVELS;
  localparam int NNODES     = 2 * NPAGES - 1;
  localparam int NODE_W     = $clog2(NNODES);
  localparam int PAGE_W     = LEVELS;
  localparam int LVL_W      = 4;
  localparam int SIZE_W     = 21;
  // Search window over one level's bitmap.
  localparam int WIN_B      = 4;
  localparam int WIN        = 1 << WIN_B;
  localparam int CHUNK_W    = (LEVELS > WIN_B) ? LEVELS - WIN_B : 1;
  localparam int CNT_W      = LEVELS + 1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_ZERO     = 2'd2,
    ST_BAD_FREE = 2'd3
  } status_t;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SEARCH = 6'b000010,
    S_SPLIT  = 6'b000100,
    S_FREE_RD = 6'b001000,
    S_MERGE  = 6'b010000,
    S_RESP   = 6'b100000
  } state_t;

  // Heap position of a block of a given level.
  function automatic logic [NODE_W-1:0] node_of(input logic [LVL_W-1:0] lvl,
                                                input logic [PAGE_W-1:0] blk);
    logic [NODE_W:0] base;
    base = (NODE_W+1)'(NPAGES) >> lvl;
    return NODE_W'(base - (NODE_W+1)'(1) + (NODE_W+1)'(blk));
  endfunction

endpackage

FILE: rtl/bpa_req_if.sv
// Request channel: allocate or free items with valid/ready handshake.
interface bpa_req_if import bpa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [SIZE_W-1:0] request_bytes;
  logic [7:0]        page_index;

  modport source (output valid, kind, request_bytes, page_index, input ready);
  modport sink   (input valid, kind, request_bytes, page_index, output ready);
endinterface

FILE: rtl/bpa_rsp_if.sv
// Response channel: status and granted block with valid/ready handshake.
interface bpa_rsp_if import bpa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [7:0]       granted_page;
  logic [LVL_W-1:0] granted_level;

  modport source (output valid, status, granted_page, granted_level, input ready);
  modport sink   (input valid, status, granted_page, granted_level, output ready);
endinterface

FILE: rtl/buddy_page_allocator_top.sv
// Buddy page allocator top level: sequencer, level bitmaps and order store.
//
// Usage: requests arrive on req (kind 0 allocate with request_bytes, kind 1
// free with page_index). Every request gives exactly one response on rsp,
// carrying a status, the block's start page and its level.
// The block handles one request at a time; req.ready is high only when idle.
// Allocate: the request is accepted, then the bitmap search reads a 16-bit window
// of one level per cycle (a level of at most 16 blocks needs a single window),
// then the split walks down level by level and records the order.
// Free: the order store is read, then the merge climbs level by level.
// Size zero and oversize requests go straight to the response.
// The search window and the single bitmap write port set the pace of these steps.
// The response sits in an output register until rsp.ready takes it; no new
// request is taken while it waits.
// Reset (rst, synchronous) marks the whole pool free and all pages unowned;
// the order store uses per-page valid bits, so no clearing pass.
module buddy_page_allocator_top
  import bpa_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  bpa_req_if.sink   req,
  bpa_rsp_if.source rsp
);

  state_t state;

  logic [NNODES-1:0]   free_map;
  logic [LVL_W-1:0]    alloc_mem [NPAGES];
  logic [NPAGES-1:0]   alloc_vld;
  logic [LVL_W-1:0]    rd_level;
  logic                rd_vld;

  logic [LVL_W-1:0]    need;
  logic [LVL_W-1:0]    lvl;
  logic [LVL_W-1:0]    orig_lvl;
  logic [CHUNK_W-1:0]  chunk;
  logic [PAGE_W-1:0]   blk;
  logic [PAGE_W-1:0]   page;

  logic [1:0]          status;
  logic [7:0]          out_page;
  logic [LVL_W-1:0]    out_level;

  // Size to level: smallest level whose block holds the request.
  logic [LVL_W-1:0] size_lvl;
  logic             size_fits;
  always_comb begin
    size_lvl  = '0;
    size_fits = 1'b0;
    for (int k = LEVELS; k >= 0; k--) begin
      if ({1'b0, req.request_bytes} <= ((SIZE_W+1)'(1) << (PAGE_SHIFT + k))) begin
        size_lvl  = LVL_W'(k);
        size_fits = 1'b1;
      end
    end
  end

  // Search window over the current level.
  logic [NNODES+WIN-1:0] fm_pad;
  logic [NODE_W:0]       win_base;
  logic [CNT_W-1:0]      offset;
  logic [CNT_W:0]        nblocks;
  logic [WIN-1:0]        win;
  logic                  win_hit;
  logic [WIN_B-1:0]      win_idx;
  logic                  last_chunk;
  always_comb begin
    fm_pad     = {{WIN{1'b0}}, free_map};
    offset     = CNT_W'({chunk, {WIN_B{1'b0}}});
    nblocks    = (CNT_W+1)'(NPAGES) >> lvl;
    win_base   = (NODE_W+1)'(node_of(lvl, '0)) + (NODE_W+1)'(offset);
    win        = fm_pad[win_base +: WIN];
    for (int i = 0; i < WIN; i++) begin
      if (({1'b0, offset} + (CNT_W+1)'(i)) >= nblocks) win[i] = 1'b0;
    end
    win_hit = |win;
    win_idx = '0;
    for (int i = WIN - 1; i >= 0; i--) begin
      if (win[i]) win_idx = WIN_B'(i);
    end
    last_chunk = ({1'b0, offset} + (CNT_W+1)'(WIN)) >= nblocks;
  end

  logic [PAGE_W-1:0] hit_blk;
  assign hit_blk = PAGE_W'(offset) + PAGE_W'(win_idx);

  // Buddy of the current block during a merge.
  logic [NODE_W-1:0] buddy_node;
  assign buddy_node = node_of(lvl, blk ^ PAGE_W'(1));

  // Order store: written and read in one clocked block, valid bits per page.
  logic              am_we;
  logic [PAGE_W-1:0] am_addr;
  logic [LVL_W-1:0]  am_data;
  always_ff @(posedge clk) begin
    if (am_we) alloc_mem[am_addr] <= am_data;
    rd_level <= alloc_mem[req.page_index[PAGE_W-1:0]];
  end

  assign am_we   = (state == S_SPLIT) && (lvl == need);
  assign am_addr = PAGE_W'(blk << need);
  assign am_data = need + LVL_W'(1);

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      free_map  <= NNODES'(1);
      alloc_vld <= '0;
      rd_vld    <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            page   <= req.page_index[PAGE_W-1:0];
            rd_vld <= alloc_vld[req.page_index[PAGE_W-1:0]];
            if (req.kind) begin
              state <= S_FREE_RD;
            end else if (req.request_bytes == '0) begin
              status <= ST_ZERO; out_page <= '0; out_level <= '0;
              state  <= S_RESP;
            end else if (!size_fits) begin
              status <= ST_NO_SPACE; out_page <= '0; out_level <= '0;
              state  <= S_RESP;
            end else begin
              need  <= size_lvl;
              lvl   <= size_lvl;
              chunk <= '0;
              state <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          if (win_hit) begin
            free_map[node_of(lvl, hit_blk)] <= 1'b0;
            blk   <= hit_blk;
            state <= S_SPLIT;
          end else if (last_chunk) begin
            if (lvl == LVL_W'(LEVELS)) begin
              status <= ST_NO_SPACE; out_page <= '0; out_level <= '0;
              state  <= S_RESP;
            end else begin
              lvl   <= lvl + LVL_W'(1);
              chunk <= '0;
            end
          end else begin
            chunk <= chunk + CHUNK_W'(1);
          end
        end
        S_SPLIT: begin
          // Keep the left half, free the right half, one level per cycle.
          if (lvl == need) begin
            alloc_vld[am_addr] <= 1'b1;
            status    <= ST_OK;
            out_page  <= 8'(am_addr);
            out_level <= need;
            state     <= S_RESP;
          end else begin
            free_map[node_of(lvl - LVL_W'(1), {blk[PAGE_W-2:0], 1'b1})] <= 1'b1;
            blk <= {blk[PAGE_W-2:0], 1'b0};
            lvl <= lvl - LVL_W'(1);
          end
        end
        S_FREE_RD: begin
          if (!rd_vld || rd_level == '0 || rd_level > LVL_W'(LEVELS + 1)) begin
            status <= ST_BAD_FREE; out_page <= '0; out_level <= '0;
            state  <= S_RESP;
          end else begin
            alloc_vld[page] <= 1'b0;
            lvl      <= rd_level - LVL_W'(1);
            orig_lvl <= rd_level - LVL_W'(1);
            blk      <= page >> (rd_level - LVL_W'(1));
            state    <= S_MERGE;
          end
        end
        S_MERGE: begin
          // Absorb the free buddy and climb, or settle the merged block.
          if (lvl < LVL_W'(LEVELS) && free_map[buddy_node]) begin
            free_map[buddy_node] <= 1'b0;
            blk <= blk >> 1;
            lvl <= lvl + LVL_W'(1);
          end else begin
            free_map[node_of(lvl, blk)] <= 1'b1;
            status    <= ST_OK;
            out_page  <= 8'(page);
            out_level <= orig_lvl;
            state     <= S_RESP;
          end
        end
        S_RESP: begin
          if (rsp.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign req.ready         = (state == S_IDLE);
  assign rsp.valid         = (state == S_RESP);
  assign rsp.status        = status;
  assign rsp.granted_page  = out_page;
  assign rsp.granted_level = out_level;

endmodule

FILE: rtl/bpa_checker.sv
// Port-level assertions for the buddy page allocator, bound to the top level.
module bpa_checker
  import bpa_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             req_valid,
  input logic             req_ready,
  input logic             rsp_valid,
  input logic             rsp_ready,
  input logic [1:0]       status,
  input logic [7:0]       granted_page,
  input logic [LVL_W-1:0] granted_level
);

  // A waiting response stays until it is taken.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  // One request at a time: no acceptance while a response is pending.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    !(req_ready && rsp_valid))
    else $error("ready while a response waits");

  // After a transfer in, the block is not ready in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("ready right after a request transfer");

  // Errors carry zero page and level.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != ST_OK |-> granted_page == 8'd0 && granted_level == '0)
    else $error("error response with nonzero fields");

  // Good responses name an aligned block inside the pool.
  a_ok_aligned: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == ST_OK |->
      granted_level <= LVL_W'(LEVELS) &&
      (granted_page & ((8'd1 << granted_level) - 8'd1)) == 8'd0)
    else $error("misaligned or oversize block");

endmodule

bind buddy_page_allocator_top bpa_checker u_bpa_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .status        (rsp.status),
  .granted_page  (rsp.granted_page),
  .granted_level (rsp.granted_level)
);

FILE: verif/bpa_tb_pkg.sv
`timescale 1ns / 100ps
// Request/response item types shared by the allocator testbench.
package bpa_tb_pkg;
  import bpa_pkg::*;

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } req_kind_t;

  typedef struct packed {
    req_kind_t         kind;
    logic [SIZE_W-1:0] request_bytes;
    logic [7:0]        page_index;
  } alloc_req_t;

  typedef struct packed {
    status_t          status;
    logic [7:0]       granted_page;
    logic [LVL_W-1:0] granted_level;
  } alloc_rsp_t;

endpackage

FILE: verif/buddy_page_allocator_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the buddy page allocator top level.
module buddy_page_allocator_top_tb;
  import bpa_pkg::*;
  import bpa_tb_pkg::*;

  localparam int RANDOM_ITEMS = 1400;
  localparam int CYCLE_LIMIT  = 400000;

  logic clk;
  logic rst;
  int   cycle_count = 0;
  int   fail_count = 0;
  int   rsp_count = 0;
  int   send_idle_pct;
  int   recv_idle_pct;

  bpa_req_if req ();
  bpa_rsp_if rsp ();

  buddy_page_allocator_top i_dut (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source)
  );

  // Shadow copy of the allocator state.
  logic             pool_free [NNODES];
  logic [LVL_W-1:0] page_order [NPAGES];

  // Expected responses in order of the request transfers.
  alloc_rsp_t granted_q [$];

  // Directed stimulus table; has_fixed marks rows with a hand-written answer.
  typedef struct {
    alloc_req_t item;
    bit         has_fixed;
    alloc_rsp_t fixed;
  } vector_t;

  vector_t vectors [$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Cycle counter with the run timeout.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int heap_node(int lvl, int blk);
    return (NPAGES >> lvl) - 1 + blk;
  endfunction

  task automatic reset_shadow();
    foreach (pool_free[i]) pool_free[i] = 1'b0;
    foreach (page_order[i]) page_order[i] = '0;
    pool_free[0] = 1'b1;
  endtask

  // Predicts the response of one request and updates the shadow state.
  function automatic alloc_rsp_t predict_grant(alloc_req_t it);
    alloc_rsp_t r;
    int need, found, blk, lvl, page, orig;
    bit have;
    r = '{status: ST_OK, granted_page: '0, granted_level: '0};
    if (it.kind == KIND_FREE) begin
      page = it.page_index % NPAGES;
      if (page_order[page] == 0 || page_order[page] > LEVELS + 1) begin
        r.status = ST_BAD_FREE;
        return r;
      end
      lvl = page_order[page] - 1;
      orig = lvl;
      page_order[page] = '0;
      blk = page >> lvl;
      while (lvl < LEVELS && pool_free[heap_node(lvl, blk ^ 1)]) begin
        pool_free[heap_node(lvl, blk ^ 1)] = 1'b0;
        blk = blk >> 1;
        lvl++;
      end
      pool_free[heap_node(lvl, blk)] = 1'b1;
      r.granted_page = 8'(page);
      r.granted_level = LVL_W'(orig);
      return r;
    end
    if (it.request_bytes == 0) begin
      r.status = ST_ZERO;
      return r;
    end
    need = -1;
    for (int k = 0; k <= LEVELS; k++) begin
      if (need < 0 && longint'(it.request_bytes) <= (longint'(1) << (PAGE_SHIFT + k)))
        need = k;
    end
    if (need < 0) begin
      r.status = ST_NO_SPACE;
      return r;
    end
    have = 1'b0;
    found = 0;
    blk = 0;
    for (int k = need; k <= LEVELS && !have; k++) begin
      for (int b = 0; b < (NPAGES >> k) && !have; b++) begin
        if (pool_free[heap_node(k, b)]) begin
          have = 1'b1;
          found = k;
          blk = b;
        end
      end
    end
    if (!have) begin
      r.status = ST_NO_SPACE;
      return r;
    end
    pool_free[heap_node(found, blk)] = 1'b0;
    for (int k = found; k > need; k--) begin
      blk = blk << 1;
      pool_free[heap_node(k - 1, blk + 1)] = 1'b1;
    end
    page_order[(blk << need) % NPAGES] = LVL_W'(need + 1);
    r.granted_page = 8'(blk << need);
    r.granted_level = LVL_W'(need);
    return r;
  endfunction

  // Sends one request and queues its expected response.
  task automatic send_request(alloc_req_t it, bit has_fixed, alloc_rsp_t fixed);
    alloc_rsp_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.kind <= it.kind;
    req.request_bytes <= it.request_bytes;
    req.page_index <= it.page_index;
    do @(posedge clk); while (!req.ready);
    r = predict_grant(it);
    if (has_fixed && r != fixed)
      $error("directed row: predictor gives %p, table says %p", r, fixed);
    granted_q.push_back(has_fixed ? fixed : r);
  endtask

  // Response side: random stalls and field-by-field compare.
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (granted_q.size() == 0) begin
          $error("response transfer with nothing expected");
          fail_count++;
        end else begin
          alloc_rsp_t e;
          e = granted_q.pop_front();
          rsp_count++;
          if (rsp.status !== e.status) begin
            $error("status: expected %0d, actual %0d", e.status, rsp.status);
            fail_count++;
          end
          if (rsp.granted_page !== e.granted_page) begin
            $error("granted_page: expected %0d, actual %0d", e.granted_page,
                   rsp.granted_page);
            fail_count++;
          end
          if (rsp.granted_level !== e.granted_level) begin
            $error("granted_level: expected %0d, actual %0d", e.granted_level,
                   rsp.granted_level);
            fail_count++;
          end
        end
      end
      rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic alloc_req_t make_alloc(int bytes);
    return '{kind: KIND_ALLOC, request_bytes: SIZE_W'(bytes),
             page_index: 8'($urandom_range(255))};
  endfunction

  function automatic alloc_req_t make_free(int page);
    return '{kind: KIND_FREE, request_bytes: SIZE_W'($urandom_range(2097151)),
             page_index: 8'(page)};
  endfunction

  task automatic add_row(alloc_req_t it, bit has_fixed, status_t st, int pg, int lv);
    vector_t v;
    v.item = it;
    v.has_fixed = has_fixed;
    v.fixed = '{status: st, granted_page: 8'(pg), granted_level: LVL_W'(lv)};
    vectors.push_back(v);
  endtask

  // Random request: mostly sizes that keep the pool busy, frees of live blocks.
  function automatic alloc_req_t random_request();
    int live [$];
    int sel;
    foreach (page_order[i]) if (page_order[i] != 0) live.push_back(i);
    sel = $urandom_range(99);
    if (sel < 45) begin
      case ($urandom_range(9))
        0:       return make_alloc($urandom_range(2097151));
        1:       return make_alloc($urandom_range(1048576));
        2:       return make_alloc(0);
        default: return make_alloc($urandom_range(4096 << $urandom_range(4)));
      endcase
    end else if (sel < 90 && live.size() > 0) begin
      return make_free(live[$urandom_range(live.size() - 1)]);
    end
    return make_free($urandom_range(255));
  endfunction

  initial begin
    alloc_rsp_t none;
    send_idle_pct = 14;
    recv_idle_pct = 70;
    rst = 1'b1;
    req.valid = 1'b0;
    req.kind = KIND_ALLOC;
    req.request_bytes = '0;
    req.page_index = '0;
    none = '0;
    reset_shadow();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows: zero size, oversize, whole pool, smallest blocks, bad frees.
    add_row(make_alloc(0), 1, ST_ZERO, 0, 0);
    add_row(make_alloc(2097151), 1, ST_NO_SPACE, 0, 0);
    add_row(make_alloc(1048577), 1, ST_NO_SPACE, 0, 0);
    add_row(make_free(0), 1, ST_BAD_FREE, 0, 0);
    add_row(make_alloc(1048576), 1, ST_OK, 0, 8);
    add_row(make_alloc(1), 1, ST_NO_SPACE, 0, 0);
    add_row(make_free(0), 1, ST_OK, 0, 8);
    add_row(make_free(0), 1, ST_BAD_FREE, 0, 0);
    add_row(make_alloc(1), 1, ST_OK, 0, 0);
    add_row(make_alloc(4096), 1, ST_OK, 1, 0);
    add_row(make_alloc(4097), 1, ST_OK, 2, 1);
    add_row(make_alloc(524288), 0, ST_OK, 0, 0);
    add_row(make_alloc(524288), 0, ST_OK, 0, 0);
    add_row(make_free(3), 1, ST_BAD_FREE, 0, 0);
    add_row(make_free(255), 1, ST_BAD_FREE, 0, 0);
    add_row(make_free(1), 0, ST_OK, 0, 0);
    add_row(make_free(0), 0, ST_OK, 0, 0);
    add_row(make_free(2), 0, ST_OK, 0, 0);
    add_row(make_alloc(65536), 0, ST_OK, 0, 0);
    add_row(make_alloc(8192), 0, ST_OK, 0, 0);
    add_row(make_free(128), 0, ST_OK, 0, 0);
    add_row('{kind: KIND_ALLOC, request_bytes: '1, page_index: '1}, 0, ST_OK, 0, 0);
    add_row('{kind: KIND_FREE, request_bytes: '1, page_index: 8'hAA}, 0, ST_OK, 0, 0);
    add_row('{kind: KIND_FREE, request_bytes: '0, page_index: 8'h55}, 0, ST_OK, 0, 0);
    foreach (vectors[i]) send_request(vectors[i].item, vectors[i].has_fixed, vectors[i].fixed);

    // Random traffic in three idling phases.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 3) begin
        send_idle_pct = 70;
        recv_idle_pct = 14;
      end else if (i == 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      send_request(random_request(), 0, none);
    end
    req.valid <= 1'b0;

    while (granted_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Ran %0d directed and %0d random requests, %0d responses checked,",
             vectors.size(), RANDOM_ITEMS, rsp_count);
    $display("covering splits, merges, exhaustion, zero size and bad frees.");
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: buddy_page_allocator_top.f
rtl/bpa_pkg.sv
rtl/bpa_req_if.sv
rtl/bpa_rsp_if.sv
rtl/buddy_page_allocator_top.sv
rtl/bpa_checker.sv
verif/bpa_tb_pkg.sv
verif/buddy_page_allocator_top_tb.sv
